// ===== rtl/ase_pkg.sv =====
// shared constants, state codes and tables for the swing estimator
package ase_pkg;

  localparam int MaxWindows  = 256;
  localparam int WinIdxW     = $clog2(MaxWindows);
  localparam int WinCntW     = WinIdxW + 1;
  localparam int SwingSteps  = 16;
  localparam int StepW       = $clog2(SwingSteps);
  localparam int VarTableLen = 64;

  localparam logic [15:0] DefaultSwing = 16'd3277;
  localparam logic [16:0] OneQ15       = 17'd32768;

  typedef logic [5:0] state_t;

  // sequencer states
  localparam state_t S_IDLE    = 6'd0;
  localparam state_t S_ACC     = 6'd1;
  localparam state_t S_DIV     = 6'd2;
  localparam state_t S_SQRT    = 6'd3;
  localparam state_t S_STORE   = 6'd4;
  localparam state_t S_CHECK   = 6'd5;
  localparam state_t S_MAXRD   = 6'd6;
  localparam state_t S_MAXCMP  = 6'd7;
  localparam state_t S_PKRD0   = 6'd8;
  localparam state_t S_PKRD1   = 6'd9;
  localparam state_t S_PKRD2   = 6'd10;
  localparam state_t S_PKCMP   = 6'd11;
  localparam state_t S_RATIO   = 6'd12;
  localparam state_t S_RATIO2  = 6'd13;
  localparam state_t S_QDIV    = 6'd14;
  localparam state_t S_STYLE   = 6'd15;
  localparam state_t S_STEPMUL = 6'd16;
  localparam state_t S_STEPDIV = 6'd17;
  localparam state_t S_EMIT    = 6'd18;
  localparam state_t S_FAIL    = 6'd19;
  localparam state_t S_DONE    = 6'd20;

  // style codes
  localparam logic [1:0] StyleStraight = 2'd0;
  localparam logic [1:0] StyleLight    = 2'd1;
  localparam logic [1:0] StyleSwing    = 2'd2;
  localparam logic [1:0] StyleHeavy    = 2'd3;

  // round(sin(0.4*i) * 0.05 * 32768)
  function automatic logic signed [11:0] var_lookup(input logic [5:0] idx);
    int v;
    v = 0;
    case (idx)
      6'd0: v = 0;      6'd1: v = 638;    6'd2: v = 1175;   6'd3: v = 1527;
      6'd4: v = 1638;   6'd5: v = 1490;   6'd6: v = 1107;   6'd7: v = 549;
      6'd8: v = -96;    6'd9: v = -725;   6'd10: v = -1240; 6'd11: v = -1559;
      6'd12: v = -1632; 6'd13: v = -1447; 6'd14: v = -1034; 6'd15: v = -458;
      6'd16: v = 191;   6'd17: v = 810;   6'd18: v = 1300;  6'd19: v = 1586;
      6'd20: v = 1621;  6'd21: v = 1400;  6'd22: v = 958;   6'd23: v = 365;
      6'd24: v = -286;  6'd25: v = -891;  6'd26: v = -1356; 6'd27: v = -1609;
      6'd28: v = -1604; 6'd29: v = -1346; 6'd30: v = -879;  6'd31: v = -271;
      6'd32: v = 379;   6'd33: v = 970;   6'd34: v = 1408;  6'd35: v = 1623;
      6'd36: v = 1582;  6'd37: v = 1291;  6'd38: v = 797;   6'd39: v = 177;
      6'd40: v = -472;  6'd41: v = -1045; 6'd42: v = -1454; 6'd43: v = -1633;
      6'd44: v = -1554; 6'd45: v = -1230; 6'd46: v = -712;  6'd47: v = -81;
      6'd48: v = 562;   6'd49: v = 1117;  6'd50: v = 1496;  6'd51: v = 1638;
      6'd52: v = 1522;  6'd53: v = 1165;  6'd54: v = 625;   6'd55: v = -15;
      6'd56: v = -650;  6'd57: v = -1185; 6'd58: v = -1531; 6'd59: v = -1637;
      6'd60: v = -1484; 6'd61: v = -1096; 6'd62: v = -535;  6'd63: v = 110;
      default: v = 0;
    endcase
    return 12'(v);
  endfunction

endpackage

// ===== rtl/audio_swing_estimator.sv =====
// swing estimator: window energy, peak interval walk and per-step swing output
//
//   channel | signals                          | dir
//   in      | in_valid in_ready in_sample ...  | in
//   out     | out_valid out_ready out_* fields | out
//   cfg     | cfg_valid cfg_ready cfg_data     | in
//
// an ordinary sample passes through S_ACC and S_CHECK; a sample that closes a
// window adds the restoring divider (64 steps), the root unit and a store
// state. the last sample adds two passes over the energy memory, 64-step
// ratio division and 16 emitted results; the restoring divider is shared
// between the window mean and the ratio division.
// reset is synchronous, active low; out_ready low holds the current result
// and the sequencer waits.
module audio_swing_estimator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_sample,
  input  logic        in_last_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [ase_pkg::StepW-1:0] out_step_index,
  output logic [15:0] out_swing_value,
  output logic [15:0] out_overall_swing,
  output logic [1:0]  out_style,
  output logic        out_success,
  output logic        out_truncated,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import ase_pkg::*;

  state_t state_r;

  logic [15:0] window_length_r;
  logic [47:0] square_sum_r;
  logic [15:0] samples_in_window_r;
  logic [WinCntW-1:0] window_count_r;
  logic overflow_r;
  logic signed [15:0] sample_r;
  logic last_r;

  // energy memory
  logic [15:0] energy_mem [MaxWindows];
  logic        mem_we;
  logic [WinIdxW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata, mem_rdata_r;

  assign mem_we    = (state_r == S_STORE) && (window_count_r < WinCntW'(MaxWindows));
  assign mem_waddr = window_count_r[WinIdxW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      energy_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= energy_mem[mem_raddr];
  end

  // shared restoring divider: num / den, one quotient bit per cycle
  logic [63:0] div_num_r;   // remaining dividend bits, shifted out at top
  logic [63:0] div_rem_r;
  logic [63:0] div_quo_r;
  logic [63:0] div_den_r;
  logic [6:0]  div_cnt_r;
  logic [64:0] div_trial;
  logic [63:0] div_shift;
  assign div_shift = {div_rem_r[62:0], div_num_r[63]};
  assign div_trial = {1'b0, div_shift} - {1'b0, div_den_r};

  // root unit: one result bit per cycle
  logic [31:0] rt_v_r, rt_res_r, rt_bit_r;
  logic [32:0] rt_sum;
  assign rt_sum = {1'b0, rt_res_r} + {1'b0, rt_bit_r};
  assign mem_wdata = rt_res_r[15:0];

  // analysis registers
  logic [15:0] peak_energy_r;
  logic [WinIdxW:0] idx_r;
  logic [15:0] e_prev_r, e_cur_r;
  logic [WinCntW-1:0] prev_peak_r;
  logic [WinCntW-1:0] peaks_r;
  logic [23:0] even_sum_r, odd_sum_r;
  logic [WinCntW-1:0] even_cnt_r, odd_cnt_r;
  logic [47:0] num_r, den_r;
  logic [16:0] overall_r;
  logic [1:0]  style_r;
  logic        valid_r;
  logic [StepW-1:0] step_r;
  logic [19:0] step_prod_r;
  logic [16:0] step_q_r;

  // output register
  logic [StepW-1:0] o_step_r;
  logic [15:0] o_swing_r, o_overall_r;
  logic [1:0]  o_style_r;
  logic        o_success_r, o_last_r, o_valid_r;

  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = o_valid_r;
  assign out_step_index = o_step_r;
  assign out_swing_value = o_swing_r;
  assign out_overall_swing = o_overall_r;
  assign out_style = o_style_r;
  assign out_success = o_success_r;
  assign out_truncated = overflow_r;
  assign out_last = o_last_r;

  // peak test pieces
  logic [19:0] e10, pk3;
  assign e10 = {4'd0, e_cur_r} * 20'd10;
  assign pk3 = {4'd0, peak_energy_r} * 20'd3;
  logic [WinCntW-1:0] gap;
  assign gap = idx_r[WinCntW-1:0] - prev_peak_r;

  // interval ratio products
  logic [32:0] num_prod, den_prod;
  assign num_prod = even_sum_r * odd_cnt_r;
  assign den_prod = even_cnt_r * odd_sum_r;

  // divide by five: reciprocal 52429 / 2^18, exact below 2^18
  logic [35:0] step_recip;
  assign step_recip = step_prod_r * 16'd52429;

  // per-step value
  logic signed [18:0] step_val;
  assign step_val = $signed({2'b00, step_q_r}) +
                    19'(var_lookup(6'(step_r)));

  logic [20:0] ov10;
  assign ov10 = {4'd0, overall_r} * 21'd10;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      window_length_r <= 16'd4800;
      square_sum_r <= '0;
      samples_in_window_r <= '0;
      window_count_r <= '0;
      overflow_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (o_valid_r && out_ready) o_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) window_length_r <= cfg_data;
          else if (in_valid) begin
            sample_r <= in_sample;
            last_r <= in_last_sample;
            state_r <= S_ACC;
          end
        end
        // accumulate square
        S_ACC: begin
          if (window_length_r != 16'd0) begin
            square_sum_r <= square_sum_r + 48'(32'(sample_r * sample_r));
            samples_in_window_r <= samples_in_window_r + 16'd1;
            state_r <= S_CHECK;
          end else begin
            state_r <= last_r ? S_FAIL : S_IDLE;
          end
        end
        S_CHECK: begin
          if (samples_in_window_r >= window_length_r) begin
            div_num_r <= {16'd0, square_sum_r};
            div_rem_r <= '0;
            div_quo_r <= '0;
            div_den_r <= {48'd0, samples_in_window_r};
            div_cnt_r <= 7'd64;
            state_r <= S_DIV;
          end else begin
            state_r <= last_r ? S_MAXRD : S_IDLE;
            idx_r <= '0;
            peak_energy_r <= '0;
            mem_raddr <= '0;
          end
        end
        // divide sum by count
        S_DIV: begin
          div_num_r <= div_num_r << 1;
          if (!div_trial[64]) begin
            div_rem_r <= div_trial[63:0];
            div_quo_r <= {div_quo_r[62:0], 1'b1};
          end else begin
            div_rem_r <= div_shift;
            div_quo_r <= {div_quo_r[62:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r - 7'd1;
          if (div_cnt_r == 7'd1) begin
            rt_res_r <= '0;
            rt_bit_r <= 32'h4000_0000;
            state_r <= S_SQRT;
          end
        end
        // square root, quotient fits 32 bits
        S_SQRT: begin
          if (div_cnt_r == 7'd0) begin
            rt_v_r <= div_quo_r[31:0];
            div_cnt_r <= 7'd1;
          end else if (rt_bit_r == 32'd0) begin
            state_r <= S_STORE;
          end else begin
            if ({1'b0, rt_v_r} >= rt_sum) begin
              rt_v_r <= rt_v_r - rt_sum[31:0];
              rt_res_r <= (rt_res_r >> 1) + rt_bit_r;
            end else begin
              rt_res_r <= rt_res_r >> 1;
            end
            rt_bit_r <= rt_bit_r >> 2;
          end
        end
        // memory write happens here when there is room
        S_STORE: begin
          if (window_count_r < WinCntW'(MaxWindows)) begin
            window_count_r <= window_count_r + 1'b1;
          end else begin
            overflow_r <= 1'b1;
          end
          square_sum_r <= '0;
          samples_in_window_r <= '0;
          idx_r <= '0;
          peak_energy_r <= '0;
          mem_raddr <= '0;
          state_r <= last_r ? S_MAXRD : S_IDLE;
        end
        // maximum pass, address runs one entry ahead
        S_MAXRD: begin
          if (window_count_r < WinCntW'(4)) begin
            valid_r <= 1'b0;
            overall_r <= {1'b0, DefaultSwing};
            state_r <= S_STYLE;
          end else if (idx_r == (WinIdxW+1)'(window_count_r)) begin
            idx_r <= (WinIdxW+1)'(1);
            prev_peak_r <= '0;
            peaks_r <= '0;
            even_sum_r <= '0; odd_sum_r <= '0;
            even_cnt_r <= '0; odd_cnt_r <= '0;
            mem_raddr <= '0;
            state_r <= S_PKRD0;
          end else begin
            mem_raddr <= WinIdxW'(idx_r + 1'b1);
            state_r <= S_MAXCMP;
          end
        end
        S_MAXCMP: begin
          if (mem_rdata_r > peak_energy_r) peak_energy_r <= mem_rdata_r;
          idx_r <= idx_r + 1'b1;
          state_r <= S_MAXRD;
        end
        // peak walk: read i-1, i, i+1
        S_PKRD0: begin
          mem_raddr <= idx_r[WinIdxW-1:0];
          state_r <= S_PKRD1;
        end
        S_PKRD1: begin
          e_prev_r <= mem_rdata_r;
          mem_raddr <= WinIdxW'(idx_r + 1'b1);
          state_r <= S_PKRD2;
        end
        S_PKRD2: begin
          e_cur_r <= mem_rdata_r;
          state_r <= S_PKCMP;
        end
        S_PKCMP: begin
          if ((idx_r + 1'b1) >= (WinIdxW+1)'(window_count_r)) begin
            state_r <= S_RATIO;
          end else begin
            if (e10 > pk3 && e_cur_r > e_prev_r && e_cur_r > mem_rdata_r) begin
              if (peaks_r != '0) begin
                if (((even_cnt_r + odd_cnt_r) & 1'b1) == '0) begin
                  even_sum_r <= even_sum_r + 24'(gap);
                  even_cnt_r <= even_cnt_r + 1'b1;
                end else begin
                  odd_sum_r <= odd_sum_r + 24'(gap);
                  odd_cnt_r <= odd_cnt_r + 1'b1;
                end
              end
              prev_peak_r <= idx_r[WinCntW-1:0];
              peaks_r <= peaks_r + 1'b1;
            end
            mem_raddr <= idx_r[WinIdxW-1:0];
            idx_r <= idx_r + 1'b1;
            state_r <= S_PKRD0;
          end
        end
        // ratio setup: even-only sums or both cross products
        S_RATIO: begin
          if (peaks_r < WinCntW'(2)) begin
            valid_r <= 1'b0;
            overall_r <= {1'b0, DefaultSwing};
            state_r <= S_STYLE;
          end else begin
            valid_r <= 1'b1;
            if (odd_cnt_r == '0) begin
              num_r <= 48'(even_sum_r);
              den_r <= 48'(even_cnt_r);
            end else begin
              num_r <= {15'd0, num_prod};
              den_r <= {15'd0, den_prod};
            end
            state_r <= S_RATIO2;
          end
        end
        S_RATIO2: begin
          if (den_r == '0 || num_r <= den_r) begin
            overall_r <= '0;
            state_r <= S_STYLE;
          end else begin
            div_num_r <= {1'b0, (num_r - den_r), 15'd0};
            div_rem_r <= '0;
            div_quo_r <= '0;
            div_den_r <= {15'd0, den_r, 1'b0};
            div_cnt_r <= 7'd64;
            state_r <= S_QDIV;
          end
        end
        S_QDIV: begin
          div_num_r <= div_num_r << 1;
          if (!div_trial[64]) begin
            div_rem_r <= div_trial[63:0];
            div_quo_r <= {div_quo_r[62:0], 1'b1};
          end else begin
            div_rem_r <= div_shift;
            div_quo_r <= {div_quo_r[62:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r - 7'd1;
          if (div_cnt_r == 7'd1) begin
            overall_r <= ({div_quo_r[62:0], ~div_trial[64]} > 64'(OneQ15)) ?
                         OneQ15 : {div_quo_r[15:0], ~div_trial[64]};
            state_r <= S_STYLE;
          end
        end
        // style classification
        S_STYLE: begin
          if (valid_r && ov10 > 21'd131072) style_r <= StyleHeavy;
          else if (valid_r && ov10 > 21'd65536) style_r <= StyleSwing;
          else if (valid_r && ov10 > 21'd32768) style_r <= StyleLight;
          else style_r <= StyleStraight;
          step_r <= '0;
          state_r <= S_STEPMUL;
        end
        // per-step: multiply, then divide by five by reciprocal multiplication
        S_STEPMUL: begin
          if (!o_valid_r) begin
            step_prod_r <= step_r[0] ? 20'(overall_r) * 20'd6 : 20'(overall_r) * 20'd4;
            state_r <= S_STEPDIV;
          end
        end
        S_STEPDIV: begin
          step_q_r <= step_recip[34:18];
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          o_valid_r <= 1'b1;
          o_step_r <= step_r;
          if (!valid_r) o_swing_r <= DefaultSwing;
          else if (step_val < 0) o_swing_r <= '0;
          else if (step_val > 19'sd32768) o_swing_r <= OneQ15[15:0];
          else o_swing_r <= step_val[15:0];
          o_overall_r <= overall_r[15:0];
          o_style_r <= style_r;
          o_success_r <= 1'b1;
          o_last_r <= (step_r == StepW'(SwingSteps - 1));
          step_r <= step_r + 1'b1;
          state_r <= (step_r == StepW'(SwingSteps - 1)) ? S_DONE : S_STEPMUL;
        end
        // zero window length
        S_FAIL: begin
          if (!o_valid_r) begin
            o_valid_r <= 1'b1;
            o_step_r <= '0;
            o_swing_r <= '0;
            o_overall_r <= '0;
            o_style_r <= StyleStraight;
            o_success_r <= 1'b0;
            o_last_r <= 1'b1;
            state_r <= S_DONE;
          end
        end
        // wait for final transfer then clear clip
        S_DONE: begin
          if (!o_valid_r || out_ready) begin
            square_sum_r <= '0;
            samples_in_window_r <= '0;
            window_count_r <= '0;
            overflow_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/audio_swing_estimator_tb.sv =====
// self-checking testbench for the audio swing estimator
module audio_swing_estimator_tb;
  import ase_pkg::*;

  typedef struct {
    logic [StepW-1:0] step_index;
    logic [15:0] swing_value;
    logic [15:0] overall_swing;
    logic [1:0] style;
    logic success;
    logic truncated;
    logic final_step;
  } swing_result_t;

  // swing offsets added to each step
  localparam int StepWobble[16] = '{0, 638, 1175, 1527, 1638, 1490, 1107, 549,
                                    -96, -725, -1240, -1559, -1632, -1447, -1034, -458};
  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 3000;

  // clip model: window energies and the swing analysis on the last sample
  class swing_scoreboard;
    bit [15:0] win_len;
    bit [63:0] sq_sum;
    int unsigned in_win;
    bit [15:0] energy[MaxWindows];
    int unsigned nwin;
    bit dropped;
    swing_result_t expected_q[$];
    int unsigned samples_seen, clips_seen, results_checked, valid_clips, truncated_clips;

    function new();
      win_len = 16'd4800;
      clear_clip();
    endfunction

    function void clear_clip();
      sq_sum = 0;
      in_win = 0;
      nwin = 0;
      dropped = 0;
    endfunction

    function bit [15:0] mean_root(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res[15:0];
    endfunction

    function void note_sample(logic signed [15:0] s, bit is_last);
      int sv;
      bit [15:0] top;
      int unsigned peaks, prev, es, os, ec, oc, i;
      bit [63:0] num, den, q;
      bit swing_ok;
      logic [15:0] overall;
      logic [1:0] sty;
      longint v;
      swing_result_t r;
      samples_seen++;
      sv = s;
      // window accumulation
      if (win_len != 0) begin
        sq_sum += 64'(longint'(sv) * longint'(sv));
        in_win++;
        if (in_win >= win_len) begin
          if (nwin < MaxWindows) begin
            energy[nwin] = mean_root(sq_sum / in_win);
            nwin++;
          end else begin
            dropped = 1;
          end
          sq_sum = 0;
          in_win = 0;
        end
      end
      if (!is_last) return;
      clips_seen++;
      if (dropped) truncated_clips++;
      // invalid window length gives one failure result
      if (win_len == 0) begin
        r = '{'0, '0, '0, StyleStraight, 1'b0, dropped, 1'b1};
        expected_q = {expected_q, r};
        clear_clip();
        return;
      end
      // peak interval walk
      overall = DefaultSwing;
      swing_ok = 0;
      if (nwin >= 4) begin
        top = 0;
        for (i = 0; i < nwin; i++) if (energy[i] > top) top = energy[i];
        peaks = 0; prev = 0; es = 0; os = 0; ec = 0; oc = 0;
        for (i = 1; i + 1 < nwin; i++) begin
          if (64'(energy[i]) * 10 > 64'(top) * 3 &&
              energy[i] > energy[i-1] && energy[i] > energy[i+1]) begin
            if (peaks > 0) begin
              if (((ec + oc) & 1) == 0) begin
                es += i - prev; ec++;
              end else begin
                os += i - prev; oc++;
              end
            end
            prev = i;
            peaks++;
          end
        end
        if (peaks >= 2) begin
          swing_ok = 1;
          if (oc == 0) begin
            num = es; den = ec;
          end else begin
            num = 64'(es) * oc; den = 64'(ec) * os;
          end
          if (den == 0 || num <= den) begin
            q = 0;
          end else begin
            q = ((num - den) * 32768) / (2 * den);
            if (q > 32768) q = 32768;
          end
          overall = q[15:0];
        end
      end
      if (swing_ok) valid_clips++;
      // style class
      sty = StyleStraight;
      if (swing_ok) begin
        if (overall * 10 > 4 * 32768) sty = StyleHeavy;
        else if (overall * 10 > 2 * 32768) sty = StyleSwing;
        else if (overall * 10 > 32768) sty = StyleLight;
      end
      // per-step values
      for (i = 0; i < SwingSteps; i++) begin
        if (swing_ok) begin
          v = (i & 1) ? (longint'(overall) * 6) / 5 : (longint'(overall) * 4) / 5;
          v += StepWobble[i];
          if (v < 0) v = 0;
          if (v > 32768) v = 32768;
        end else begin
          v = DefaultSwing;
        end
        r = '{i[StepW-1:0], v[15:0], overall, sty, 1'b1, dropped, i == SwingSteps - 1};
        expected_q = {expected_q, r};
      end
      clear_clip();
    endfunction

    function bit check(swing_result_t got, output string why);
      swing_result_t exp_r;
      why = "";
      if (expected_q.size() == 0) begin
        why = $sformatf("unexpected result step %0d", got.step_index);
        return 0;
      end
      exp_r = expected_q.pop_front();
      results_checked++;
      if (got.step_index !== exp_r.step_index)
        why = {why, $sformatf(" step %0d/%0d", got.step_index, exp_r.step_index)};
      if (got.swing_value !== exp_r.swing_value)
        why = {why, $sformatf(" swing %0d/%0d", got.swing_value, exp_r.swing_value)};
      if (got.overall_swing !== exp_r.overall_swing)
        why = {why, $sformatf(" overall %0d/%0d", got.overall_swing, exp_r.overall_swing)};
      if (got.style !== exp_r.style)
        why = {why, $sformatf(" style %0d/%0d", got.style, exp_r.style)};
      if (got.success !== exp_r.success)
        why = {why, $sformatf(" success %0b/%0b", got.success, exp_r.success)};
      if (got.truncated !== exp_r.truncated)
        why = {why, $sformatf(" truncated %0b/%0b", got.truncated, exp_r.truncated)};
      if (got.final_step !== exp_r.final_step)
        why = {why, $sformatf(" last %0b/%0b", got.final_step, exp_r.final_step)};
      return why == "";
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, in_last_sample;
  logic signed [15:0] in_sample;
  logic out_valid, out_ready;
  logic [StepW-1:0] out_step_index;
  logic [15:0] out_swing_value, out_overall_swing;
  logic [1:0] out_style;
  logic out_success, out_truncated, out_last;
  logic cfg_valid, cfg_ready;
  logic [15:0] cfg_data;

  swing_scoreboard sb;
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned settings_used;
  bit hold_done;

  audio_swing_estimator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample(in_sample), .in_last_sample(in_last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_step_index(out_step_index), .out_swing_value(out_swing_value),
    .out_overall_swing(out_overall_swing), .out_style(out_style),
    .out_success(out_success), .out_truncated(out_truncated), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  task automatic report(string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // one sample transfer, with bursts and gaps on the sender side
  task automatic send_sample(logic signed [15:0] s, bit is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_sample <= s;
    in_last_sample <= is_last;
    in_valid <= 1'b1;
    forever begin
      @(negedge clk);
      if (in_valid && in_ready) break;
    end
    sb.note_sample(s, is_last);
    @(posedge clk);
    burst_left--;
  endtask

  // wait until the block is idle, then write the window length
  task automatic write_window(logic [15:0] v);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    forever begin
      @(negedge clk);
      if (cfg_valid && cfg_ready) break;
    end
    sb.win_len = v;
    settings_used++;
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // clip of nwin windows with loud windows on alternating gaps
  task automatic send_clip(int unsigned nwin, bit noisy);
    int unsigned gap_a, gap_b, next_peak, w, k, amp, extra, total, n;
    bit flip;
    logic signed [15:0] s;
    gap_a = $urandom_range(1, 4);
    gap_b = $urandom_range(1, 4);
    next_peak = $urandom_range(1, 2);
    flip = 0;
    extra = $urandom_range(0, 2) == 0 ? $urandom_range(0, sb.win_len - 1) : 0;
    total = nwin * sb.win_len + extra;
    n = 0;
    for (w = 0; n < total; w++) begin
      if (noisy) begin
        amp = $urandom_range(0, 32767);
      end else if (w == next_peak) begin
        amp = $urandom_range(16000, 32767);
        next_peak += flip ? gap_b : gap_a;
        flip = !flip;
      end else begin
        amp = $urandom_range(0, 4000);
      end
      for (k = 0; k < sb.win_len && n < total; k++) begin
        s = 16'($urandom_range(0, 1) ? -int'(amp) - $urandom_range(0, 1)
                                     : int'(amp) - $urandom_range(0, amp / 8));
        n++;
        send_sample(s, n == total);
      end
    end
  endtask

  // receiver stalls, with one long hold-off while the sender keeps offering
  initial begin
    int unsigned mode, hold;
    out_ready = 1'b0;
    hold_done = 0;
    mode = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 2);
      if (!hold_done && sb != null && sb.samples_seen > 150 && out_valid) begin
        hold = 600;
        hold_done = 1;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result check and watchdog
  always @(negedge clk) begin
    swing_result_t got;
    string why;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_step_index, out_swing_value, out_overall_swing, out_style,
                out_success, out_truncated, out_last};
        if (!sb.check(got, why)) report(why);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("audio_swing_estimator_tb NOT OK");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned c;
    sb = new();
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    settings_used = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_last_sample = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default length: no full window, default swing
    send_sample(16'sh7FFF, 0);
    send_sample(-16'sh8000, 0);
    send_sample(16'sh0000, 1);
    // zero length: failure result
    write_window(16'd0);
    send_sample(16'sh5555, 0);
    send_sample(-16'sh2AAB, 1);
    // single-sample windows with three peaks
    write_window(16'd1);
    send_sample(16'sd100, 0);
    send_sample(16'sd30000, 0);
    send_sample(-16'sd100, 0);
    send_sample(16'sd100, 0);
    send_sample(-16'sh8000, 0);
    send_sample(16'sd100, 0);
    send_sample(16'sd100, 0);
    send_sample(16'sd100, 0);
    send_sample(16'sh7FFF, 0);
    send_sample(16'sd100, 1);
    // widest window, then shrink it mid-window
    write_window(16'd65535);
    send_sample(16'sh7FFF, 0);
    send_sample(16'sh1234, 1);
    send_sample(-16'sh8000, 0);
    send_sample(16'sh7FFF, 0);
    send_sample(16'sh0F0F, 0);
    write_window(16'd2);

    // random clips
    for (c = 0; c < 4; c++) send_clip($urandom_range(2, 12), $urandom_range(0, 4) == 0);
    write_window(16'd3);
    for (c = 0; c < 2; c++) send_clip($urandom_range(2, 10), $urandom_range(0, 4) == 0);
    write_window(16'd1);
    send_clip(MaxWindows + 4, 0);
    for (c = 0; c < 4; c++) send_clip($urandom_range(3, 14), $urandom_range(0, 4) == 0);
    in_valid <= 1'b0;

    // drain
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (sb.expected_q.size() != 0) report($sformatf("%0d results missing", sb.expected_q.size()));
    $display("covered %0d samples in %0d clips (%0d with measured swing, %0d truncated)",
             sb.samples_seen, sb.clips_seen, sb.valid_clips, sb.truncated_clips);
    $display("checked %0d results over %0d window length writes, %0d mismatches",
             sb.results_checked, settings_used, errors);
    if (errors == 0)
      $display("audio_swing_estimator_tb OK");
    else
      $display("audio_swing_estimator_tb NOT OK");
    $finish;
  end

endmodule
